// ===== sv/fwst_pkg.sv =====
// fwst_pkg: shared types and constants for the spectral surface tension update unit.
// Beat layouts, register indexes, reset values and fixed-point limits.
// No dependencies.
package fwst_pkg;

	localparam int ROWS = 256;
	localparam int COLS = 256;
	localparam int IDX_W = 13;
	localparam int M_W = 12;
	localparam int Q_W = 24;

	localparam int CFG_W = 25;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSIVITY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IFACE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_ORDER = 3'd4;

	localparam logic [16:0] RST_TIME_STEP = 17'd655;
	localparam logic [24:0] RST_DIFFUSIVITY = 25'd65536;
	localparam logic [24:0] RST_WAVE_SCALE = 25'd65536;
	localparam logic [24:0] RST_IFACE_WIDTH = 25'd65536;
	localparam logic [17:0] RST_FRAC_ORDER = 18'd98304;

	localparam logic [17:0] ONE_Q = 18'h10000;
	localparam logic [17:0] TWO_Q = 18'h20000;
	localparam logic [47:0] QCAP = 48'h8000_0000_0000;

	localparam logic signed [49:0] V_MAX = 50'sd2147483647;
	localparam logic signed [49:0] V_MIN = -50'sd2147483648;

	localparam int DIV_STEPS = 32;
	localparam int LATENCY = 42;
	localparam int PAYLOAD_LAG = 39;
	localparam int PAY_DEPTH = 64;
	localparam int PAY_AW = 6;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic signed [31:0] f_real;
		logic signed [31:0] f_imag;
		logic signed [31:0] w_real;
		logic signed [31:0] w_imag;
		logic signed [31:0] r_real;
		logic signed [31:0] r_imag;
	} item_t;

	typedef struct packed {
		logic signed [31:0] res_real;
		logic signed [31:0] res_imag;
		logic overflow;
	} result_t;

	typedef struct packed {
		logic [31:0] f_real;
		logic [31:0] f_imag;
		logic [31:0] w_real;
		logic [31:0] w_imag;
		logic [31:0] r_real;
		logic [31:0] r_imag;
	} pay_t;

endpackage

// ===== sv/frac_wave_surface_tension_update_unit.sv =====
// Top level of the spectral fractional-wave surface tension update.
// Depends on fwst_pkg and fwst_ram.
// A start beat passes stages 1 to 7, the 32-stage restoring divider, stage 41 and
// stage 42 before the done strobe; throughput one beat per cycle, busy stays low.
// The f, w, r operands wait in a 64-entry RAM while the coefficients are formed.
// Reset loads the register defaults and empties the pipeline; no clearing pass.
module frac_wave_surface_tension_update_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  fwst_pkg::item_t                   item,
	output logic                              done,
	output fwst_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [fwst_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fwst_pkg::CFG_W-1:0]        cfg_data
);

	typedef struct packed {
		logic [47:0] rem;
		logic [31:0] low;
		logic [31:0] quo;
	} lane_t;

	typedef struct packed {
		logic        zero;
		logic [2:0]  clamp;
		logic [47:0] den;
		lane_t [2:0] ln;
	} dstg_t;

	function automatic lane_t div_step(input lane_t x, input logic [47:0] den);
		lane_t r;
		logic [48:0] t;
		t = {x.rem, x.low[31]};
		r.low = {x.low[30:0], 1'b0};
		if (t >= {1'b0, den}) begin
			r.rem = 48'(t - {1'b0, den});
			r.quo = {x.quo[30:0], 1'b1};
		end else begin
			r.rem = t[47:0];
			r.quo = {x.quo[30:0], 1'b0};
		end
		return r;
	endfunction

	logic accept;
	assign busy = 1'b0;
	assign accept = start && !busy;

	// configuration
	logic [16:0] dt_q;
	logic [24:0] dif_q;
	logic [24:0] scl_q;
	logic [24:0] eps_q;
	logic [17:0] alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= fwst_pkg::RST_TIME_STEP;
			dif_q <= fwst_pkg::RST_DIFFUSIVITY;
			scl_q <= fwst_pkg::RST_WAVE_SCALE;
			eps_q <= fwst_pkg::RST_IFACE_WIDTH;
			alpha_q <= fwst_pkg::RST_FRAC_ORDER;
		end else if (cfg_we) begin
			case (cfg_idx)
				fwst_pkg::REG_TIME_STEP: dt_q <= cfg_data[16:0];
				fwst_pkg::REG_DIFFUSIVITY: dif_q <= cfg_data;
				fwst_pkg::REG_WAVE_SCALE: scl_q <= cfg_data;
				fwst_pkg::REG_IFACE_WIDTH: eps_q <= cfg_data;
				fwst_pkg::REG_FRAC_ORDER: alpha_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	logic [17:0] ac;
	always_comb begin
		if (alpha_q < fwst_pkg::ONE_Q) begin
			ac = fwst_pkg::ONE_Q;
		end else if (alpha_q > fwst_pkg::TWO_Q) begin
			ac = fwst_pkg::TWO_Q;
		end else begin
			ac = alpha_q;
		end
	end

	// payload buffer
	logic [fwst_pkg::PAY_AW-1:0] wp_q;
	logic [fwst_pkg::PAY_AW-1:0] rd_addr;
	fwst_pkg::pay_t pay_wr;
	fwst_pkg::pay_t pay_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else begin
			wp_q <= wp_q + 1'b1;
		end
	end

	assign rd_addr = wp_q - fwst_pkg::PAY_AW'(fwst_pkg::PAYLOAD_LAG);
	assign pay_wr = '{f_real: item.f_real, f_imag: item.f_imag,
		w_real: item.w_real, w_imag: item.w_imag,
		r_real: item.r_real, r_imag: item.r_imag};

	fwst_ram #(
		.WIDTH($bits(fwst_pkg::pay_t)),
		.DEPTH(fwst_pkg::PAY_DEPTH)
	) u_pay_ram (
		.clk(clk),
		.we(accept),
		.waddr(wp_q),
		.wdata(pay_wr),
		.raddr(rd_addr),
		.rdata(pay_rd)
	);

	// stage 1: folded wavenumbers, dt^2
	logic [fwst_pkg::IDX_W-1:0] ri, ci;
	logic [fwst_pkg::M_W-1:0] mr, mc;
	logic [33:0] p_dt2;

	// grid sizes are powers of two
	assign ri = fwst_pkg::IDX_W'(item.row) % fwst_pkg::IDX_W'(fwst_pkg::ROWS);
	assign ci = fwst_pkg::IDX_W'(item.col) % fwst_pkg::IDX_W'(fwst_pkg::COLS);
	assign mr = (ri <= fwst_pkg::IDX_W'(fwst_pkg::ROWS / 2)) ? fwst_pkg::M_W'(ri)
		: fwst_pkg::M_W'(fwst_pkg::IDX_W'(fwst_pkg::ROWS) - ri);
	assign mc = (ci <= fwst_pkg::IDX_W'(fwst_pkg::COLS / 2)) ? fwst_pkg::M_W'(ci)
		: fwst_pkg::M_W'(fwst_pkg::IDX_W'(fwst_pkg::COLS) - ci);
	assign p_dt2 = dt_q * dt_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [fwst_pkg::M_W-1:0] mr_s1, mc_s1;
	logic [17:0] dt2_s1, dt2_s2, dt2_s3, dt2_s4, dt2_s5, dt2_s6, dt2_s7;

	always_ff @(posedge clk) begin
		mr_s1 <= mr;
		mc_s1 <= mc;
		dt2_s1 <= p_dt2[33:16];
	end

	// stage 2
	logic [fwst_pkg::Q_W-1:0] q_c, q_s2, q_s3;
	logic [42:0] p_c;
	logic [34:0] p_t1;
	logic [34:0] p_ta;
	logic [49:0] p_ee;
	logic [26:0] c_s2;
	logic [17:0] t1_s2, t1_s3;
	logic [18:0] ta_s2;
	logic [33:0] ee_s2;

	assign q_c = fwst_pkg::Q_W'(mr_s1) * fwst_pkg::Q_W'(mr_s1)
		+ fwst_pkg::Q_W'(mc_s1) * fwst_pkg::Q_W'(mc_s1);
	assign p_c = dt2_s1 * dif_q;
	assign p_t1 = ac * (ac - fwst_pkg::ONE_Q);
	assign p_ta = dt_q * ac;
	assign p_ee = eps_q * eps_q;

	always_ff @(posedge clk) begin
		q_s2 <= q_c;
		c_s2 <= p_c[42:16];
		t1_s2 <= p_t1[34:17];
		ta_s2 <= p_ta[34:16];
		ee_s2 <= p_ee[49:16];
		dt2_s2 <= dt2_s1;
	end

	// stage 3
	logic [51:0] p_cs;
	logic [60:0] p_cee;
	logic [35:0] p_t2;
	logic [48:0] p_sq;
	logic [35:0] cs_s3;
	logic [44:0] cee_s3, cee_s4;
	logic [18:0] t2_s3;
	logic [47:0] sq_s3;

	assign p_cs = c_s2 * scl_q;
	assign p_cee = c_s2 * ee_s2;
	assign p_t2 = ta_s2 * (fwst_pkg::TWO_Q - ac);
	assign p_sq = scl_q * q_s2;

	always_ff @(posedge clk) begin
		cs_s3 <= p_cs[51:16];
		cee_s3 <= p_cee[60:16];
		t2_s3 <= p_t2[35:17];
		sq_s3 <= (p_sq > 49'(fwst_pkg::QCAP)) ? fwst_pkg::QCAP : p_sq[47:0];
		q_s3 <= q_s2;
		t1_s3 <= t1_s2;
		dt2_s3 <= dt2_s2;
	end

	// stage 4
	logic [59:0] p_a;
	logic [63:0] p_sqq;
	logic [47:0] a_s4, a_s5, a_s6, a_s7;
	logic [47:0] sqq_s4;
	logic [19:0] t12_s4, t12_s5, t12_s6;

	assign p_a = cs_s3 * q_s3;
	assign p_sqq = sq_s3[31:0] * sq_s3[31:0];

	always_ff @(posedge clk) begin
		a_s4 <= (p_a > 60'(fwst_pkg::QCAP)) ? fwst_pkg::QCAP : p_a[47:0];
		sqq_s4 <= (|sq_s3[47:32] || p_sqq[63:16] > fwst_pkg::QCAP) ? fwst_pkg::QCAP
			: p_sqq[63:16];
		t12_s4 <= 20'(t1_s3) + 20'(t2_s3);
		cee_s4 <= cee_s3;
		dt2_s4 <= dt2_s3;
	end

	// stage 5: partial products of the surface term
	logic [44:0] p_hh, p_hl;
	logic [47:0] p_lh, p_ll;
	logic [44:0] hh_s5, hl_s5;
	logic [47:0] lh_s5, ll_s5;

	assign p_hh = cee_s4[44:24] * sqq_s4[47:24];
	assign p_hl = cee_s4[44:24] * sqq_s4[23:0];
	assign p_lh = cee_s4[23:0] * sqq_s4[47:24];
	assign p_ll = cee_s4[23:0] * sqq_s4[23:0];

	always_ff @(posedge clk) begin
		hh_s5 <= p_hh;
		hl_s5 <= p_hl;
		lh_s5 <= p_lh;
		ll_s5 <= p_ll;
		a_s5 <= a_s4;
		t12_s5 <= t12_s4;
		dt2_s5 <= dt2_s4;
	end

	// stage 6
	logic [92:0] p_t3;
	logic [47:0] t3_s6;

	assign p_t3 = (93'(hh_s5) << 48) + (93'(hl_s5) << 24) + (93'(lh_s5) << 24) + 93'(ll_s5);

	always_ff @(posedge clk) begin
		t3_s6 <= (p_t3[92:16] > 77'(fwst_pkg::QCAP)) ? fwst_pkg::QCAP : p_t3[63:16];
		a_s6 <= a_s5;
		t12_s6 <= t12_s5;
		dt2_s6 <= dt2_s5;
	end

	// stage 7: denominator
	logic [48:0] den_sum;
	logic [47:0] den_s7;

	assign den_sum = 49'(t12_s6) + 49'(t3_s6);

	always_ff @(posedge clk) begin
		den_s7 <= (den_sum > 49'(fwst_pkg::QCAP)) ? fwst_pkg::QCAP : den_sum[47:0];
		a_s7 <= a_s6;
		dt2_s7 <= dt2_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// divider: b = 2^32/den, ba = a*2^16/den, bd = dt2*2^16/den
	dstg_t div_s [0:fwst_pkg::DIV_STEPS];
	logic div_vld [0:fwst_pkg::DIV_STEPS];

	always_ff @(posedge clk) begin
		div_s[0].zero <= (den_s7 == '0);
		div_s[0].clamp[0] <= (den_s7 == 48'd1);
		div_s[0].clamp[1] <= ({16'h0, a_s7} >= {den_s7, 16'h0});
		div_s[0].clamp[2] <= ({46'h0, dt2_s7} >= {den_s7, 16'h0});
		div_s[0].den <= den_s7;
		div_s[0].ln[0] <= '{rem: 48'd1, low: 32'h0, quo: 32'h0};
		div_s[0].ln[1] <= '{rem: 48'(a_s7[47:16]), low: {a_s7[15:0], 16'h0}, quo: 32'h0};
		div_s[0].ln[2] <= '{rem: 48'(dt2_s7[17:16]), low: {dt2_s7[15:0], 16'h0},
			quo: 32'h0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld[0] <= 1'b0;
		end else begin
			div_vld[0] <= vld_s7;
		end
	end

	for (genvar k = 0; k < fwst_pkg::DIV_STEPS; k++) begin : g_div
		dstg_t nxt;

		always_comb begin
			nxt = div_s[k];
			for (int j = 0; j < 3; j++) begin
				nxt.ln[j] = div_step(div_s[k].ln[j], div_s[k].den);
			end
		end

		always_ff @(posedge clk) begin
			div_s[k+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld[k+1] <= 1'b0;
			end else begin
				div_vld[k+1] <= div_vld[k];
			end
		end
	end

	// stage 41: coefficient times operand
	dstg_t dl;
	logic [31:0] coef [3];
	logic [31:0] x_val [6];
	logic [31:0] x_mag [6];
	logic [63:0] x_prod [6];
	logic vld_s41;
	logic zero_s41;
	logic cflag_s41;
	logic [47:0] tm_s41 [6];
	logic sg_s41 [6];

	assign dl = div_s[fwst_pkg::DIV_STEPS];
	assign x_val[0] = pay_rd.f_real;
	assign x_val[1] = pay_rd.w_real;
	assign x_val[2] = pay_rd.r_real;
	assign x_val[3] = pay_rd.f_imag;
	assign x_val[4] = pay_rd.w_imag;
	assign x_val[5] = pay_rd.r_imag;

	for (genvar j = 0; j < 3; j++) begin : g_coef
		assign coef[j] = dl.clamp[j] ? 32'hFFFF_FFFF : dl.ln[j].quo;
	end

	for (genvar n = 0; n < 6; n++) begin : g_term
		assign x_mag[n] = x_val[n][31] ? 32'(-x_val[n]) : x_val[n];
		assign x_prod[n] = 64'(coef[n % 3]) * 64'(x_mag[n]);

		always_ff @(posedge clk) begin
			tm_s41[n] <= x_prod[n][63:16];
			sg_s41[n] <= x_val[n][31];
		end
	end

	always_ff @(posedge clk) begin
		zero_s41 <= dl.zero;
		cflag_s41 <= |dl.clamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s41 <= 1'b0;
		end else begin
			vld_s41 <= div_vld[fwst_pkg::DIV_STEPS];
		end
	end

	// stage 42: sum and saturate
	logic signed [49:0] tv [6];
	logic signed [49:0] v_re, v_im;
	logic [31:0] sat_re, sat_im;
	logic ovf_re, ovf_im;
	logic done_q;
	fwst_pkg::result_t result_q;

	for (genvar n = 0; n < 6; n++) begin : g_sign
		assign tv[n] = sg_s41[n] ? -$signed({2'b00, tm_s41[n]}) : $signed({2'b00, tm_s41[n]});
	end

	assign v_re = tv[0] - tv[1] + tv[2];
	assign v_im = tv[3] - tv[4] + tv[5];
	assign ovf_re = (v_re > fwst_pkg::V_MAX) || (v_re < fwst_pkg::V_MIN);
	assign ovf_im = (v_im > fwst_pkg::V_MAX) || (v_im < fwst_pkg::V_MIN);
	assign sat_re = (v_re > fwst_pkg::V_MAX) ? 32'h7FFF_FFFF
		: ((v_re < fwst_pkg::V_MIN) ? 32'h8000_0000 : v_re[31:0]);
	assign sat_im = (v_im > fwst_pkg::V_MAX) ? 32'h7FFF_FFFF
		: ((v_im < fwst_pkg::V_MIN) ? 32'h8000_0000 : v_im[31:0]);

	always_ff @(posedge clk) begin
		if (zero_s41) begin
			result_q.res_real <= '0;
			result_q.res_imag <= '0;
			result_q.overflow <= 1'b1;
		end else begin
			result_q.res_real <= sat_re;
			result_q.res_imag <= sat_im;
			result_q.overflow <= cflag_s41 | ovf_re | ovf_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s41;
		end
	end

	assign done = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(fwst_pkg::LATENCY) done)
		else $error("result beat missing at fixed latency");

	a_pay_align: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(fwst_pkg::PAYLOAD_LAG) (rd_addr == $past(wp_q, fwst_pkg::PAYLOAD_LAG)))
		else $error("payload read address out of step with pipeline");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s41 && zero_s41) |=> (done && result.overflow && result.res_real == 0
			&& result.res_imag == 0))
		else $error("zero denominator result not forced");

endmodule

// ===== sv/fwst_ram.sv =====
// fwst_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fwst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for frac_wave_surface_tension_update_unit.
// Random and directed beats are checked against a built-in fixed-point predictor.
// Depends on fwst_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [63:0] CAP = 64'h0000_8000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	fwst_pkg::item_t item = '0;
	logic done;
	fwst_pkg::result_t result;
	logic cfg_we = 1'b0;
	logic [fwst_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [fwst_pkg::CFG_W-1:0] cfg_data = '0;

	fwst_pkg::item_t pending_items[$];
	fwst_pkg::result_t expected_results[$];
	int send_idle_pct = 0;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int flagged = 0;
	int quiet_cycles = 0;

	logic [63:0] dt_q, diff_q, scale_q, eps_q, alpha_q;

	frac_wave_surface_tension_update_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] fx_mul(input logic [63:0] x, input logic [63:0] y);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		if (p[127:64] != 0)
			return CAP;
		p = p >> 16;
		return (p[63:0] > CAP) ? CAP : p[63:0];
	endfunction

	function automatic logic [63:0] wave_sq(input logic [7:0] idx);
		logic [63:0] m;
		m = (idx <= 8'd128) ? 64'(idx) : 64'(256 - idx);
		return m * m;
	endfunction

	function automatic logic [63:0] coef_div(input logic [63:0] num, input logic [63:0] den,
			inout logic flag);
		logic [63:0] c;
		c = num / den;
		if (c > 64'hFFFF_FFFF) begin
			flag = 1'b1;
			c = 64'hFFFF_FFFF;
		end
		return c;
	endfunction

	function automatic longint scaled_term(input logic [63:0] c, input logic signed [31:0] x);
		longint xs;
		longint unsigned mag, p;
		xs = x;
		mag = (xs < 0) ? -xs : xs;
		p = (c * mag) >> 16;
		return (xs < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic signed [31:0] clip32(input longint v, inout logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic fwst_pkg::result_t surface_update(input fwst_pkg::item_t it);
		fwst_pkg::result_t r;
		logic flag;
		logic [63:0] alpha, qq, dt2, c, a, t1, t2, t3, sq, den, b, ba, bd;
		flag = 1'b0;
		alpha = alpha_q;
		if (alpha < 64'h10000) alpha = 64'h10000;
		if (alpha > 64'h20000) alpha = 64'h20000;
		qq = (wave_sq(it.row) + wave_sq(it.col)) << 16;
		dt2 = fx_mul(dt_q, dt_q);
		c = fx_mul(dt2, diff_q);
		a = fx_mul(fx_mul(c, scale_q), qq);
		t1 = fx_mul(alpha, alpha - 64'h10000) >> 1;
		t2 = fx_mul(fx_mul(dt_q, alpha), 64'h20000 - alpha) >> 1;
		sq = fx_mul(scale_q, qq);
		t3 = fx_mul(fx_mul(c, fx_mul(eps_q, eps_q)), fx_mul(sq, sq));
		den = t1 + t2 + t3;
		if (den > CAP) den = CAP;
		if (den == 0) begin
			r.res_real = '0;
			r.res_imag = '0;
			r.overflow = 1'b1;
			return r;
		end
		b = coef_div(64'h1_0000_0000, den, flag);
		ba = coef_div(a << 16, den, flag);
		bd = coef_div(dt2 << 16, den, flag);
		r.res_real = clip32(scaled_term(b, it.f_real) - scaled_term(ba, it.w_real)
			+ scaled_term(bd, it.r_real), flag);
		r.res_imag = clip32(scaled_term(b, it.f_imag) - scaled_term(ba, it.w_imag)
			+ scaled_term(bd, it.r_imag), flag);
		r.overflow = flag;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (start) begin
				expected_results.push_back(surface_update(item));
				beats_in++;
			end
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= pending_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			beats_out++;
			if (result.overflow) flagged++;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				fwst_pkg::result_t e;
				e = expected_results.pop_front();
				if (result.res_real !== e.res_real) begin
					$error("res_real expected %0d got %0d", e.res_real, result.res_real);
					errors++;
				end
				if (result.res_imag !== e.res_imag) begin
					$error("res_imag expected %0d got %0d", e.res_imag, result.res_imag);
					errors++;
				end
				if (result.overflow !== e.overflow) begin
					$error("overflow expected %0b got %0b", e.overflow, result.overflow);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("frac_wave_surface_tension_update_unit verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [fwst_pkg::CFG_IDX_W-1:0] idx,
			input logic [fwst_pkg::CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fwst_pkg::REG_TIME_STEP: dt_q = 64'(data[16:0]);
			fwst_pkg::REG_DIFFUSIVITY: diff_q = 64'(data);
			fwst_pkg::REG_WAVE_SCALE: scale_q = 64'(data);
			fwst_pkg::REG_IFACE_WIDTH: eps_q = 64'(data);
			fwst_pkg::REG_FRAC_ORDER: alpha_q = 64'(data[17:0]);
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [fwst_pkg::CFG_W-1:0] dt,
			input logic [fwst_pkg::CFG_W-1:0] d,
			input logic [fwst_pkg::CFG_W-1:0] s, input logic [fwst_pkg::CFG_W-1:0] eps,
			input logic [fwst_pkg::CFG_W-1:0] al);
		write_reg(fwst_pkg::REG_TIME_STEP, dt);
		write_reg(fwst_pkg::REG_DIFFUSIVITY, d);
		write_reg(fwst_pkg::REG_WAVE_SCALE, s);
		write_reg(fwst_pkg::REG_IFACE_WIDTH, eps);
		write_reg(fwst_pkg::REG_FRAC_ORDER, al);
	endtask

	task automatic drain;
		wait (pending_items.size() == 0 && !start);
		wait (expected_results.size() == 0);
		repeat (fwst_pkg::LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word;
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic fwst_pkg::item_t rand_item;
		fwst_pkg::item_t it;
		it.row = 8'($urandom);
		it.col = 8'($urandom);
		it.f_real = rand_word();
		it.f_imag = rand_word();
		it.w_real = rand_word();
		it.w_imag = rand_word();
		it.r_real = rand_word();
		it.r_imag = rand_word();
		return it;
	endfunction

	task automatic add_directed(input logic [7:0] rw, input logic [7:0] cl,
			input logic [31:0] v, input logic [31:0] u);
		fwst_pkg::item_t it;
		it = '{rw, cl, v, u, u, v, v, u};
		pending_items.push_back(it);
	endtask

	task automatic random_phase(input int n, input int idle);
		send_idle_pct = idle;
		repeat (n) pending_items.push_back(rand_item());
		drain();
	endtask

	initial begin
		dt_q = 64'(fwst_pkg::RST_TIME_STEP);
		diff_q = 64'(fwst_pkg::RST_DIFFUSIVITY);
		scale_q = 64'(fwst_pkg::RST_WAVE_SCALE);
		eps_q = 64'(fwst_pkg::RST_IFACE_WIDTH);
		alpha_q = 64'(fwst_pkg::RST_FRAC_ORDER);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: grid wrap points and data extremes
		add_directed(8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000);
		add_directed(8'd1, 8'd255, 32'h8000_0000, 32'h7FFF_FFFF);
		add_directed(8'd127, 8'd128, 32'h0, 32'hFFFF_FFFF);
		add_directed(8'd128, 8'd129, 32'h0001_0000, 32'hFFFF_0000);
		add_directed(8'd255, 8'd1, 32'hFFFF_FFFF, 32'h0);
		add_directed(8'd129, 8'd127, 32'h5555_5555, 32'hAAAA_AAAA);
		drain();
		// zero denominator, then tiny denominator so coefficients clamp
		set_all(25'd1, 25'd65536, 25'd65536, 25'd65536, 25'd65536);
		add_directed(8'd0, 8'd0, 32'h7FFF_FFFF, 32'h1);
		add_directed(8'd200, 8'd3, 32'h8000_0000, 32'h1);
		drain();
		write_reg(fwst_pkg::REG_TIME_STEP, 25'd2);
		add_directed(8'd0, 8'd0, 32'h0000_0001, 32'hFFFF_FFFF);
		add_directed(8'd7, 8'd9, 32'h7FFF_FFFF, 32'h8000_0000);
		drain();
		// alpha below and above range, unknown register indexes
		set_all(25'd65536, 25'h1FF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF, 25'd0);
		write_reg(3'd5, 25'h1FF_FFFF);
		write_reg(3'd7, 25'd0);
		add_directed(8'd0, 8'd0, 32'h0001_0000, 32'h7FFF_FFFF);
		add_directed(8'd128, 8'd128, 32'h8000_0000, 32'h0001_0000);
		drain();
		write_reg(fwst_pkg::REG_FRAC_ORDER, 25'h3_FFFF);
		add_directed(8'd0, 8'd0, 32'h0001_0000, 32'h7FFF_FFFF);
		add_directed(8'd64, 8'd192, 32'h1234_5678, 32'h8765_4321);
		drain();

		// random phases over several settings
		set_all(25'd655, 25'd65536, 25'd65536, 25'd65536, 25'd98304);
		random_phase(150, 0);
		set_all(25'd1, 25'd0, 25'd0, 25'd0, 25'd65536);
		random_phase(100, 59);
		set_all(25'h1_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF, 25'h1FF_FFFF, 25'h3_FFFF);
		random_phase(100, 10);
		set_all(25'd65536, 25'd16, 25'd256, 25'd4096, 25'd131072);
		random_phase(100, 59);
		set_all(25'd3277, 25'd32768, 25'd512, 25'd1024, 25'd80000);
		random_phase(150, 0);
		for (int k = 0; k < 5; k++) begin
			set_all(fwst_pkg::CFG_W'($urandom), fwst_pkg::CFG_W'($urandom),
				fwst_pkg::CFG_W'($urandom), fwst_pkg::CFG_W'($urandom),
				fwst_pkg::CFG_W'($urandom));
			random_phase(100, (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 59 : 10));
		end
		send_idle_pct = 0;

		$display("beats: %0d sent, %0d checked, %0d flagged overflow", beats_in, beats_out,
			flagged);
		$display("covered reset, extreme, zero-denominator, clamped-alpha and random settings");
		if (errors == 0)
			$display("frac_wave_surface_tension_update_unit verification clean");
		else
			$display("frac_wave_surface_tension_update_unit verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/fwst_pkg.sv
sv/fwst_ram.sv
sv/frac_wave_surface_tension_update_unit.sv
tb/tb.sv
